### hdl/pthc_pkg.sv
// Package for the PTH sensor compensation block: payload structs,
// register map and fixed-point helper functions.
// No dependencies.
package pthc_pkg;

  typedef struct packed {
    logic [19:0] temp_adc;
    logic [19:0] press_adc;
    logic [15:0] hum_adc;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic [16:0]        humidity_q10;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_TEMP_CALIB       = 3'd0,
    REG_PRESS_CALIB_LOW  = 3'd1,
    REG_PRESS_CALIB_HIGH = 3'd2,
    REG_PRESS_CALIB_LAST = 3'd3,
    REG_HUM_CALIB_MAIN   = 3'd4,
    REG_HUM_CALIB_PAIR   = 3'd5
  } reg_idx_e;

  localparam int unsigned AddrW   = 6;
  localparam int unsigned DataW   = 64;
  localparam int unsigned DivBits = 32;

  localparam logic [31:0] HumMax  = 32'd419430400;

  // Arithmetic right shift of a 32-bit two's complement word.
  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned k);
    return $unsigned($signed(x) >>> k);
  endfunction

  // Divide by 2^k, truncating toward zero.
  function automatic logic [31:0] tdiv32(input logic [31:0] x, input int unsigned k);
    logic [31:0] n;
    n = 32'd0 - x;
    return x[31] ? (32'd0 - (n >> k)) : (x >> k);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] x);
    return {{20{x[11]}}, x};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

endpackage

### hdl/pth_sensor_compensation.sv
// Top level of the PTH sensor compensation pipeline: calibration registers,
// temperature / pressure / humidity datapath and a pipelined divider.
// Depends on pthc_pkg.
//
// Pipeline: 50 register stages, mostly in the 32-stage restoring divider.
// Throughput: one sample per cycle; every stage, the divider included
// (one quotient bit per stage), is fully pipelined.
// A stalled output holds the whole pipeline in place.
// Reset clears all valid bits and the calibration registers to zero.
module pth_sensor_compensation (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pthc_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pthc_pkg::out_item_t        out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pthc_pkg::AddrW-1:0] paddr,
  input  logic [pthc_pkg::DataW-1:0] pwdata,
  output logic [pthc_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import pthc_pkg::*;

  localparam int unsigned NPre  = 14;
  localparam int unsigned NStg  = NPre + DivBits + 4;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] acc;
    logic [31:0] d;
    logic        post;
    logic        zero;
    logic [31:0] temp;
    logic [16:0] hum;
  } div_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] d;
    logic        post;
    logic        zero;
  } pre_t;

  // ---------------- configuration ----------------
  logic [47:0] temp_calib_q;
  logic [63:0] press_low_q, press_high_q;
  logic [15:0] press_last_q;
  logic [39:0] hum_main_q;
  logic [23:0] hum_pair_q;
  logic        wr_en;
  reg_idx_e    wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = reg_idx_e'(paddr[AddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_low_q  <= '0;
      press_high_q <= '0;
      press_last_q <= '0;
      hum_main_q   <= '0;
      hum_pair_q   <= '0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_TEMP_CALIB:       temp_calib_q <= pwdata[47:0];
        REG_PRESS_CALIB_LOW:  press_low_q  <= pwdata;
        REG_PRESS_CALIB_HIGH: press_high_q <= pwdata;
        REG_PRESS_CALIB_LAST: press_last_q <= pwdata[15:0];
        REG_HUM_CALIB_MAIN:   hum_main_q   <= pwdata[39:0];
        REG_HUM_CALIB_PAIR:   hum_pair_q   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_TEMP_CALIB:       prdata = {16'd0, temp_calib_q};
      REG_PRESS_CALIB_LOW:  prdata = press_low_q;
      REG_PRESS_CALIB_HIGH: prdata = press_high_q;
      REG_PRESS_CALIB_LAST: prdata = {48'd0, press_last_q};
      REG_HUM_CALIB_MAIN:   prdata = {24'd0, hum_main_q};
      REG_HUM_CALIB_PAIR:   prdata = {40'd0, hum_pair_q};
      default:              prdata = '0;
    endcase
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, temp_calib_q[15:0]};
  assign t2 = sx16(temp_calib_q[31:16]);
  assign t3 = sx16(temp_calib_q[47:32]);
  assign p1 = {16'd0, press_low_q[15:0]};
  assign p2 = sx16(press_low_q[31:16]);
  assign p3 = sx16(press_low_q[47:32]);
  assign p5 = sx16(press_high_q[15:0]);
  assign p6 = sx16(press_high_q[31:16]);
  assign p7 = sx16(press_high_q[47:32]);
  assign p8 = sx16(press_high_q[63:48]);
  assign p9 = sx16(press_last_q);
  assign h1 = {24'd0, hum_main_q[7:0]};
  assign h2 = sx16(hum_main_q[23:8]);
  assign h3 = {24'd0, hum_main_q[31:24]};
  assign h6 = sx8(hum_main_q[39:32]);
  assign h4 = sx12(hum_pair_q[11:0]);
  assign h5 = sx12(hum_pair_q[23:12]);

  // ---------------- flow control ----------------
  logic [NStg-1:0] vld_q;
  logic            adv;

  assign adv         = ~vld_q[NStg-1] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // ---------------- front stages ----------------
  logic [19:0] rp_q [1:8];
  logic [15:0] rh_q [1:6];
  logic [31:0] a_q, b_q, m1_q, m2_q, tv1_q, m3_q, fine_q;
  logic [31:0] temp_q [5:NPre];
  logic [31:0] pv1_q, hv1_q, qq_q, mp5_q, mp2_q, mh5_q, mh6_q, mh3_q;
  logic [31:0] mp6_q, mp3_q, mp5b_q, mp2b_q, v5a_q [7:10], x2_q, x3_q;
  logic [31:0] pv2_q, pv1b_q, hm_q, d9_q, pn_q, mh2_q, y2_q;
  logic [31:0] v3_q [11:13], aa_q, mh1_q;
  logic [16:0] hum_q;
  pre_t        pre_q [10:NPre];
  logic [31:0] q6, v5_14, ha12;

  assign q6    = asr32(pv1_q, 2);
  assign ha12  = tdiv32(v3_q[11], 15);
  assign v5_14 = v3_q[13] - tdiv32(mh1_q, 4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // temperature
      a_q    <= {15'd0, in_item_i.temp_adc[19:3]} - {t1[30:0], 1'b0};
      b_q    <= {16'd0, in_item_i.temp_adc[19:4]} - t1;
      rp_q[1] <= in_item_i.press_adc;
      rh_q[1] <= in_item_i.hum_adc;
      for (int i = 2; i <= 8; i++) rp_q[i] <= rp_q[i-1];
      for (int i = 2; i <= 6; i++) rh_q[i] <= rh_q[i-1];
      m1_q   <= a_q * t2;
      m2_q   <= b_q * b_q;
      tv1_q  <= asr32(m1_q, 11);
      m3_q   <= asr32(m2_q, 12) * t3;
      fine_q <= tv1_q + asr32(m3_q, 14);
      temp_q[5] <= asr32(fine_q * 32'd5 + 32'd128, 8);
      for (int i = 6; i <= NPre; i++) temp_q[i] <= temp_q[i-1];
      pv1_q  <= asr32(fine_q, 1) - 32'd64000;
      hv1_q  <= fine_q - 32'd76800;
      // stage 6
      qq_q   <= q6 * q6;
      mp5_q  <= pv1_q * p5;
      mp2_q  <= p2 * pv1_q;
      mh5_q  <= h5 * hv1_q;
      mh6_q  <= hv1_q * h6;
      mh3_q  <= hv1_q * h3;
      // stage 7
      mp6_q  <= asr32(qq_q, 11) * p6;
      mp3_q  <= p3 * asr32(qq_q, 13);
      mp5b_q <= mp5_q;
      mp2b_q <= mp2_q;
      v5a_q[7] <= tdiv32((({2'd0, rh_q[6], 14'd0} - {h4[11:0], 20'd0}) - mh5_q)
                         + 32'd16384, 15);
      for (int i = 8; i <= 10; i++) v5a_q[i] <= v5a_q[i-1];
      x2_q   <= tdiv32(mh6_q, 10);
      x3_q   <= tdiv32(mh3_q, 11);
      // stage 8
      pv2_q  <= asr32(mp6_q + {mp5b_q[30:0], 1'b0}, 2) + {press_low_q[63:48], 16'd0};
      pv1b_q <= asr32(asr32(mp3_q, 3) + asr32(mp2b_q, 1), 18);
      hm_q   <= x2_q * (x3_q + 32'd32768);
      // stage 9
      d9_q   <= asr32((32'd32768 + pv1b_q) * p1, 15);
      pn_q   <= ((32'd1048576 - {12'd0, rp_q[8]}) - asr32(pv2_q, 12)) * 32'd3125;
      mh2_q  <= (tdiv32(hm_q, 10) + 32'd2097152) * h2;
      // stage 10: pick numerator form, flag zero divisor
      pre_q[10].num  <= pn_q[31] ? pn_q : {pn_q[30:0], 1'b0};
      pre_q[10].post <= pn_q[31];
      pre_q[10].zero <= (d9_q == 32'd0);
      pre_q[10].d    <= d9_q;
      for (int i = 11; i <= NPre; i++) pre_q[i] <= pre_q[i-1];
      y2_q   <= tdiv32(mh2_q + 32'd8192, 14);
      // stages 11..14: humidity tail
      v3_q[11] <= v5a_q[10] * y2_q;
      aa_q     <= ha12 * ha12;
      v3_q[12] <= v3_q[11];
      mh1_q    <= tdiv32(aa_q, 7) * h1;
      v3_q[13] <= v3_q[12];
      if (v5_14[31]) begin
        hum_q <= '0;
      end else if (v5_14 > HumMax) begin
        hum_q <= HumMax[28:12];
      end else begin
        hum_q <= v5_14[28:12];
      end
    end
  end

  // ---------------- divider ----------------
  function automatic div_t div_step(input div_t s);
    div_t        r;
    logic [32:0] t, diff;
    r    = s;
    t    = {s.rem, s.acc[31]};
    diff = t - {1'b0, s.d};
    r.acc = {s.acc[30:0], ~diff[32]};
    r.rem = diff[32] ? t[31:0] : diff[31:0];
    return r;
  endfunction

  div_t dv_q [1:DivBits];
  div_t dv_in;

  always_comb begin
    dv_in.rem  = '0;
    dv_in.acc  = pre_q[NPre].num;
    dv_in.d    = pre_q[NPre].d;
    dv_in.post = pre_q[NPre].post;
    dv_in.zero = pre_q[NPre].zero;
    dv_in.temp = temp_q[NPre];
    dv_in.hum  = hum_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[1] <= div_step(dv_in);
      for (int k = 2; k <= DivBits; k++) dv_q[k] <= div_step(dv_q[k-1]);
    end
  end

  // ---------------- pressure tail ----------------
  logic [31:0] pa_q, pb_q, pc_q, sq_q, mp8_q, mp8c_q, m9_q;
  logic        za_q, zb_q, zc_q;
  logic [31:0] ta_q, tb_q, tc_q;
  logic [16:0] ua_q, ub_q, uc_q;
  out_item_t   out_q;
  logic [31:0] pfin;

  assign pfin = pc_q + asr32(asr32(m9_q, 12) + asr32(mp8c_q, 13) + p7, 4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q   <= dv_q[DivBits].post ? {dv_q[DivBits].acc[30:0], 1'b0}
                                   : dv_q[DivBits].acc;
      za_q   <= dv_q[DivBits].zero;
      ta_q   <= dv_q[DivBits].temp;
      ua_q   <= dv_q[DivBits].hum;
      sq_q   <= {3'd0, pa_q[31:3]} * {3'd0, pa_q[31:3]};
      mp8_q  <= {2'd0, pa_q[31:2]} * p8;
      pb_q   <= pa_q;
      zb_q   <= za_q;
      tb_q   <= ta_q;
      ub_q   <= ua_q;
      m9_q   <= p9 * {13'd0, sq_q[31:13]};
      mp8c_q <= mp8_q;
      pc_q   <= pb_q;
      zc_q   <= zb_q;
      tc_q   <= tb_q;
      uc_q   <= ub_q;
      out_q.temperature_centi <= $signed(tc_q);
      out_q.pressure_pa       <= zc_q ? 32'd0 : pfin;
      out_q.humidity_q10      <= uc_q;
    end
  end

  assign out_item_o = out_q;

endmodule

### hdl/pthc_checker.sv
// Port-level checker for the PTH sensor compensation block, bound to
// the top level. Depends on pthc_pkg.
module pthc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input pthc_pkg::in_item_t         in_item_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input pthc_pkg::out_item_t        out_item_o,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [pthc_pkg::AddrW-1:0] paddr,
  input logic [pthc_pkg::DataW-1:0] pwdata,
  input logic [pthc_pkg::DataW-1:0] prdata,
  input logic                       pready
);
  import pthc_pkg::*;

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Input side stalls only behind a blocked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.humidity_q10 <= 17'd102400)
    else $error("humidity out of range");

  // No result right after reset release.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind pth_sensor_compensation pthc_checker u_pthc_checker (.*);
